### hdl/mmio_region_decoder_defines.svh
// Assertion macros shared by the checker of the address region decoder.
`ifndef MMIO_REGION_DECODER_DEFINES_SVH
`define MMIO_REGION_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### hdl/mrd_pkg.sv
package mrd_pkg;

    // Default sizing
    localparam int REGION_SLOTS_DEF   = 16;
    localparam int TARGET_ID_BITS_DEF = 8;

    // Fixed field widths
    localparam int DATA_BITS      = 64;
    localparam int END_BITS       = 65;
    localparam int TID_PORT_BITS  = 8;
    localparam int COUNT_BITS     = 5;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    // Operation codes
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_ACCESS     = 2'd2;
    localparam logic [1:0] OP_NOP        = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERLAP   = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_UNMAPPED  = 3'd4;

    // Classified item as it waits in the queue
    typedef struct packed {
        logic [1:0]               op;
        logic [TID_PORT_BITS-1:0] tid;
        logic [DATA_BITS-1:0]     base;
        logic [END_BITS-1:0]      rend;
        logic                     zero_size;
        logic [DATA_BITS-1:0]     addr;
        logic                     is_write;
        logic [DATA_BITS-1:0]     wval;
        logic [3:0]               alen;
    } item_t;

    // One result item
    typedef struct packed {
        logic [2:0]               status;
        logic                     hit;
        logic [TID_PORT_BITS-1:0] routed_target;
        logic [DATA_BITS-1:0]     region_offset;
        logic                     routed_is_write;
        logic [DATA_BITS-1:0]     routed_value;
        logic [3:0]               routed_len;
        logic [COUNT_BITS-1:0]    region_count;
    } res_t;

endpackage

### hdl/mrd_ram.sv
module mrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mrd_front.sv
module mrd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic [7:0]            target_id,
    input  logic [63:0]           region_base,
    input  logic [63:0]           region_size,
    input  logic [63:0]           access_address,
    input  logic                  is_write,
    input  logic [63:0]           write_value,
    input  logic [3:0]            access_len,
    output mrd_pkg::item_t        head,
    output logic                  head_valid,
    input  logic                  pop
);

    localparam int QD = mrd_pkg::QUEUE_DEPTH;
    localparam int PW = mrd_pkg::QUEUE_PTR_BITS;
    localparam int NW = mrd_pkg::QUEUE_CNT_BITS;

    mrd_pkg::item_t queue_reg [QD];
    mrd_pkg::item_t new_item;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic           push;

    // Classify the incoming item: exact region end, empty region, write data (zero for reads)
    always_comb
    begin
        new_item.op        = operation;
        new_item.tid       = target_id;
        new_item.base      = region_base;
        new_item.rend      = {1'b0, region_base} + {1'b0, region_size};
        new_item.zero_size = (region_size == '0);
        new_item.addr      = access_address;
        new_item.is_write  = is_write;
        new_item.wval      = is_write ? write_value : '0;
        new_item.alen      = access_len;
    end

    assign busy       = (cnt_reg == NW'(QD));
    assign push       = start && !busy;
    assign head       = queue_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### hdl/mrd_back.sv
module mrd_back #(
    parameter int REGION_SLOTS   = mrd_pkg::REGION_SLOTS_DEF,
    parameter int TARGET_ID_BITS = mrd_pkg::TARGET_ID_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mrd_pkg::item_t head,
    input  logic           head_valid,
    output logic           pop,
    output mrd_pkg::res_t  result,
    output logic           result_valid
);

    localparam int IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam int TW = TARGET_ID_BITS;
    localparam int DW = mrd_pkg::DATA_BITS;
    localparam int XW = mrd_pkg::END_BITS;
    localparam int KW = mrd_pkg::COUNT_BITS;
    localparam int PB = mrd_pkg::TID_PORT_BITS;
    localparam int EW = DW + XW + TW;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]             state_reg, state_next;
    mrd_pkg::item_t         cur_reg, cur_next;
    logic [IW:0]            issue_reg, issue_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [IW-1:0]          rd_slot_reg, rd_slot_next;
    logic [REGION_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   overlap_reg, overlap_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_slot_reg, free_slot_next;
    logic                   hit_reg, hit_next;
    logic [TW-1:0]          hit_owner_reg, hit_owner_next;
    logic [DW-1:0]          hit_base_reg, hit_base_next;
    mrd_pkg::res_t          res_reg, res_next;
    logic                   done_reg, done_next;

    logic                   ram_we, ram_re;
    logic [IW-1:0]          ram_waddr, ram_raddr;
    logic [EW-1:0]          ram_wdata, ram_rdata;

    logic [DW-1:0]          e_base;
    logic [XW-1:0]          e_end;
    logic [TW-1:0]          e_owner;
    logic                   e_valid;
    logic [TW+PB-1:0]       tid_ext;
    logic [TW-1:0]          tid_m;
    logic [TW+PB-1:0]       own_ext;
    logic [CW+KW-1:0]       cnt_ext;
    logic                   ov_hit, in_hit;

    // Region table: base, exact end and owner per slot
    mrd_ram #(
        .WIDTH(EW),
        .DEPTH(REGION_SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Unpack the entry read back and match it against the current item
    always_comb
    begin
        e_base  = ram_rdata[DW-1:0];
        e_end   = ram_rdata[DW+XW-1:DW];
        e_owner = ram_rdata[EW-1:DW+XW];
        e_valid = valid_reg[rd_slot_reg];
        tid_ext = {TW'(0), cur_reg.tid};
        tid_m   = tid_ext[TW-1:0];
        own_ext = {PB'(0), hit_owner_reg};
        ov_hit  = ({1'b0, cur_reg.base} < e_end) && ({1'b0, e_base} < cur_reg.rend);
        in_hit  = (cur_reg.addr >= e_base) && ({1'b0, cur_reg.addr} < e_end);
    end

    // Sequence: pop, scan every slot unless NOP or zero-size, finish
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        issue_next      = issue_reg;
        rd_pend_next    = rd_pend_reg;
        rd_slot_next    = rd_slot_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        overlap_next    = overlap_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        hit_next        = hit_reg;
        hit_owner_next  = hit_owner_reg;
        hit_base_next   = hit_base_reg;
        res_next        = res_reg;
        done_next       = 1'b0;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = issue_reg[IW-1:0];
        ram_waddr       = free_slot_reg;
        ram_wdata       = {tid_m, cur_reg.rend, cur_reg.base};
        cnt_ext         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop             = 1'b1;
                    cur_next        = head;
                    issue_next      = '0;
                    rd_pend_next    = 1'b0;
                    overlap_next    = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    if (head.op == mrd_pkg::OP_NOP ||
                        (head.op == mrd_pkg::OP_REGISTER && head.zero_size))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read
                if (issue_reg < (IW + 1)'(REGION_SLOTS))
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_slot_next = issue_reg[IW-1:0];
                    issue_next   = issue_reg + 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                // Evaluate the slot read last cycle
                if (rd_pend_reg)
                begin
                    unique case (cur_reg.op)
                        mrd_pkg::OP_REGISTER:
                        begin
                            if (e_valid && ov_hit)
                            begin
                                overlap_next = 1'b1;
                            end
                            if (!e_valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_slot_next  = rd_slot_reg;
                            end
                        end
                        mrd_pkg::OP_UNREGISTER:
                        begin
                            if (e_valid && e_owner == tid_m)
                            begin
                                valid_next[rd_slot_reg] = 1'b0;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        mrd_pkg::OP_ACCESS:
                        begin
                            if (e_valid && in_hit && !hit_reg)
                            begin
                                hit_next       = 1'b1;
                                hit_owner_next = e_owner;
                                hit_base_next  = e_base;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (rd_slot_reg == IW'(REGION_SLOTS - 1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                res_next                 = '0;
                res_next.status          = mrd_pkg::ST_OK;
                unique case (cur_reg.op)
                    mrd_pkg::OP_REGISTER:
                    begin
                        if (cur_reg.zero_size)
                        begin
                            res_next.status = mrd_pkg::ST_ZERO_SIZE;
                        end
                        else if (overlap_reg)
                        begin
                            res_next.status = mrd_pkg::ST_OVERLAP;
                        end
                        else if (!free_found_reg)
                        begin
                            res_next.status = mrd_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we                    = 1'b1;
                            valid_next[free_slot_reg] = 1'b1;
                            count_next                = count_reg + 1'b1;
                        end
                    end
                    mrd_pkg::OP_ACCESS:
                    begin
                        res_next.routed_is_write = cur_reg.is_write;
                        res_next.routed_value    = cur_reg.wval;
                        res_next.routed_len      = cur_reg.alen;
                        if (hit_reg)
                        begin
                            res_next.hit           = 1'b1;
                            res_next.routed_target = own_ext[PB-1:0];
                            res_next.region_offset = cur_reg.addr - hit_base_reg;
                        end
                        else
                        begin
                            res_next.status = mrd_pkg::ST_UNMAPPED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                cnt_ext               = {KW'(0), count_next};
                res_next.region_count = cnt_ext[KW-1:0];
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_pend_reg    <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            overlap_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            issue_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pend_reg    <= rd_pend_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            overlap_reg    <= overlap_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            issue_reg      <= issue_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        rd_slot_reg   <= rd_slot_next;
        free_slot_reg <= free_slot_next;
        hit_owner_reg <= hit_owner_next;
        hit_base_reg  <= hit_base_next;
        res_reg       <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = done_reg;

endmodule

### hdl/mmio_region_decoder.sv
// Address region decoder with a table of REGION_SLOTS regions.
// Command channel: an item (operation and its fields) is taken at a rising edge
// with start high and busy low. busy rises while the two-entry input queue is
// full. Operations: register a region, unregister all regions of a target,
// route an access, or no operation.
// Result channel: done is high for exactly one cycle with the result fields;
// the receiver cannot stall, so every result must be taken in that cycle.
// Throughput: register, unregister and access read the table one
// slot per cycle through a single read port, so each scans every slot
// before done, and the back end takes the next item only after that;
// zero-size registers and no-operation items skip the scan. The queue
// takes up to two more items while a scan runs.
// Reset: the table is emptied (all slots free, region count zero), the queue is
// emptied and no result is pending.
module mmio_region_decoder #(
    parameter int REGION_SLOTS   = mrd_pkg::REGION_SLOTS_DEF,
    parameter int TARGET_ID_BITS = mrd_pkg::TARGET_ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  target_id,
    input  logic [63:0] region_base,
    input  logic [63:0] region_size,
    input  logic [63:0] access_address,
    input  logic        is_write,
    input  logic [63:0] write_value,
    input  logic [3:0]  access_len,
    output logic        done,
    output logic [2:0]  status,
    output logic        hit,
    output logic [7:0]  routed_target,
    output logic [63:0] region_offset,
    output logic        routed_is_write,
    output logic [63:0] routed_value,
    output logic [3:0]  routed_len,
    output logic [4:0]  region_count
);

    mrd_pkg::item_t head;
    logic           head_valid;
    logic           pop;
    mrd_pkg::res_t  result;

    // Accept and classify items
    mrd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .target_id     (target_id),
        .region_base   (region_base),
        .region_size   (region_size),
        .access_address(access_address),
        .is_write      (is_write),
        .write_value   (write_value),
        .access_len    (access_len),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop)
    );

    // Carry out items against the region table
    mrd_back #(
        .REGION_SLOTS  (REGION_SLOTS),
        .TARGET_ID_BITS(TARGET_ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .result      (result),
        .result_valid(done)
    );

    assign status          = result.status;
    assign hit             = result.hit;
    assign routed_target   = result.routed_target;
    assign region_offset   = result.region_offset;
    assign routed_is_write = result.routed_is_write;
    assign routed_value    = result.routed_value;
    assign routed_len      = result.routed_len;
    assign region_count    = result.region_count;

endmodule

### hdl/mrd_checker.sv
`include "mmio_region_decoder_defines.svh"

module mrd_checker #(
    parameter int REGION_SLOTS = mrd_pkg::REGION_SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [2:0]  status,
    input logic        hit,
    input logic [7:0]  routed_target,
    input logic [63:0] region_offset,
    input logic        routed_is_write,
    input logic [63:0] routed_value,
    input logic [4:0]  region_count
);

    localparam int CNT_LIMIT = (REGION_SLOTS < 32) ? REGION_SLOTS : 31;

    // A miss carries no target and no offset
    `ASSERT_IMPLY(a_miss_zero, clk, rst_n, done && !hit, routed_target == '0 && region_offset == '0)
    // A hit always reports ok
    `ASSERT_IMPLY(a_hit_ok, clk, rst_n, done && hit, status == mrd_pkg::ST_OK)
    // Reads forward no data
    `ASSERT_IMPLY(a_read_zero, clk, rst_n, done && !routed_is_write, routed_value == '0)
    // The table never holds more regions than slots
    `ASSERT_IMPLY(a_count_max, clk, rst_n, done, region_count <= 5'(CNT_LIMIT))
    // done never stays high on consecutive cycles
    `ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done)

endmodule

bind mmio_region_decoder mrd_checker #(
    .REGION_SLOTS(REGION_SLOTS)
) u_mrd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .status         (status),
    .hit            (hit),
    .routed_target  (routed_target),
    .region_offset  (region_offset),
    .routed_is_write(routed_is_write),
    .routed_value   (routed_value),
    .region_count   (region_count)
);
